// ----- src/key_press_classifier_unit_assert.svh -----
// Assertion macros shared by the key press classifier modules.
`ifndef KEY_PRESS_CLASSIFIER_UNIT_ASSERT_SVH
`define KEY_PRESS_CLASSIFIER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

`define KPC_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("key press classifier check failed");

`define KPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("key press classifier sequence check failed");

`else

`define KPC_ASSERT(lbl, clk, rst_n, prop)

`define KPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ----- src/kpc_pkg.sv -----
package kpc_pkg;

	localparam int FIELD_KEYS = 4;
	localparam int KEY_COUNT_DEFAULT = 4;
	localparam int TICK_W = 8;
	localparam int CFG_DATA_W = 8;
	localparam int CFG_INDEX_W = 1;

	localparam logic [TICK_W-1:0] TICK_MAX = '1;
	localparam logic [TICK_W-1:0] LONG_PRESS_RESET = 8'd70;
	localparam logic [TICK_W-1:0] DOUBLE_WINDOW_RESET = 8'd35;

	localparam logic [CFG_INDEX_W-1:0] CFG_LONG_PRESS = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] CFG_DOUBLE_WINDOW = 1'b1;

	typedef enum logic [1:0] {
		PH_IDLE     = 2'd0,
		PH_DEBOUNCE = 2'd1,
		PH_HELD     = 2'd2
	} phase_t;

	typedef struct packed {
		logic is_short;
		logic is_double;
		logic is_long;
	} kpc_event_t;

endpackage

// ----- src/kpc_if.sv -----
interface kpc_in_if;
	logic                            valid;
	logic                            ready;
	logic [kpc_pkg::FIELD_KEYS-1:0]  key_levels;

	modport source (output valid, output key_levels, input ready);
	modport sink (input valid, input key_levels, output ready);
endinterface

interface kpc_out_if;
	logic                            valid;
	logic                            ready;
	logic [kpc_pkg::FIELD_KEYS-1:0]  short_events;
	logic [kpc_pkg::FIELD_KEYS-1:0]  double_events;
	logic [kpc_pkg::FIELD_KEYS-1:0]  long_events;

	modport source (output valid, output short_events, output double_events,
		output long_events, input ready);
	modport sink (input valid, input short_events, input double_events,
		input long_events, output ready);
endinterface

// ----- src/kpc_lane.sv -----
`include "key_press_classifier_unit_assert.svh"

module kpc_lane (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              accept,
	input  logic                              pressed,
	input  logic [kpc_pkg::TICK_W-1:0]        long_ticks,
	input  logic [kpc_pkg::TICK_W-1:0]        window_len,
	output kpc_pkg::kpc_event_t               events
);

	kpc_pkg::phase_t             phase_q, phase_d;
	logic [kpc_pkg::TICK_W-1:0]  held_q, held_d;
	logic                        win_open_q, win_open_d;
	logic [kpc_pkg::TICK_W-1:0]  win_cnt_q, win_cnt_d;
	logic                        doubled;

	always_comb begin
		phase_d    = phase_q;
		held_d     = held_q;
		win_open_d = win_open_q;
		win_cnt_d  = win_cnt_q;
		events     = '0;
		doubled    = 1'b0;
		case (phase_q)
			kpc_pkg::PH_DEBOUNCE: begin
				phase_d = pressed ? kpc_pkg::PH_HELD : kpc_pkg::PH_IDLE;
			end
			kpc_pkg::PH_HELD: begin
				if (!pressed) begin
					if (held_q <= long_ticks) begin
						if (!win_open_q) begin
							win_open_d = 1'b1;
							win_cnt_d  = '0;
						end else begin
							events.is_double = 1'b1;
							win_open_d       = 1'b0;
							doubled          = 1'b1;
						end
					end
					phase_d = kpc_pkg::PH_IDLE;
				end else begin
					if (held_q > long_ticks) begin
						events.is_long = 1'b1;
					end
					if (held_q != kpc_pkg::TICK_MAX) begin
						held_d = held_q + 1'b1;
					end
				end
			end
			default: begin
				if (pressed) begin
					phase_d = kpc_pkg::PH_DEBOUNCE;
					held_d  = '0;
				end else begin
					phase_d = kpc_pkg::PH_IDLE;
				end
			end
		endcase
		if (win_open_d && !doubled) begin
			if (win_cnt_d != kpc_pkg::TICK_MAX) begin
				win_cnt_d = win_cnt_d + 1'b1;
			end
			if (win_cnt_d >= window_len) begin
				events.is_short = 1'b1;
				win_open_d      = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= kpc_pkg::PH_IDLE;
			held_q     <= '0;
			win_open_q <= 1'b0;
			win_cnt_q  <= '0;
		end else if (accept) begin
			phase_q    <= phase_d;
			held_q     <= held_d;
			win_open_q <= win_open_d;
			win_cnt_q  <= win_cnt_d;
		end
	end

	`KPC_ASSERT(a_short_double_exclusive, clk, arst_n,
		!(events.is_short && events.is_double))
	`KPC_ASSERT(a_long_only_when_held, clk, arst_n,
		!events.is_long || (phase_q == kpc_pkg::PH_HELD))
	`KPC_ASSERT_NEXT(a_idle_keeps_window, clk, arst_n, !accept,
		$stable(win_cnt_q) && $stable(win_open_q) && $stable(held_q))
	`KPC_ASSERT_NEXT(a_double_closes_window, clk, arst_n,
		accept && events.is_double, !win_open_q)

endmodule

// ----- src/kpc_merge.sv -----
`include "key_press_classifier_unit_assert.svh"

module kpc_merge #(
	parameter int LANE_COUNT = kpc_pkg::FIELD_KEYS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  kpc_pkg::kpc_event_t  lane_events [LANE_COUNT],
	kpc_out_if.source            event_out
);

	logic [kpc_pkg::FIELD_KEYS-1:0] short_mask, double_mask, long_mask;
	logic [kpc_pkg::FIELD_KEYS-1:0] short_q, double_q, long_q;
	logic                           valid_q;

	for (genvar g = 0; g < kpc_pkg::FIELD_KEYS; g++) begin : g_mask
		if (g < LANE_COUNT) begin : g_live
			assign short_mask[g]  = lane_events[g].is_short;
			assign double_mask[g] = lane_events[g].is_double;
			assign long_mask[g]   = lane_events[g].is_long;
		end else begin : g_absent
			assign short_mask[g]  = 1'b0;
			assign double_mask[g] = 1'b0;
			assign long_mask[g]   = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (accept) begin
			valid_q <= 1'b1;
		end else if (event_out.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			short_q  <= short_mask;
			double_q <= double_mask;
			long_q   <= long_mask;
		end
	end

	assign event_out.valid         = valid_q;
	assign event_out.short_events  = short_q;
	assign event_out.double_events = double_q;
	assign event_out.long_events   = long_q;

	`KPC_ASSERT_NEXT(a_accept_gives_result, clk, arst_n, accept, valid_q)
	`KPC_ASSERT(a_no_overwrite, clk, arst_n,
		!(accept && valid_q && !event_out.ready))
	`KPC_ASSERT(a_result_masks_disjoint, clk, arst_n,
		!valid_q || ((short_q & double_q) == '0))

endmodule

// ----- src/key_press_classifier_unit.sv -----
// Key press classifier: each input transaction is one scan tick carrying the raw
// active-low levels of four keys, and each tick returns exactly one output
// transaction with per-key short, double-click and long event masks. A key must
// read pressed on two ticks in a row before its hold time is counted; holding it
// beyond long_press_ticks raises a long event every tick, a release at or below
// that threshold opens a double-click window or closes an open one with a double
// event, and a window open for double_window_ticks ticks ends in a short event.
// One lane per key updates its state in the cycle the tick is accepted and the
// result appears from the output register in the next cycle, so one tick is
// taken per clock cycle whenever the output side keeps taking results. Keys
// beyond the fourth are ignored. Registers are written through cfg_we,
// cfg_index (0: long_press_ticks, 1: double_window_ticks) and cfg_data; the user
// must write them only while no tick is in flight; the block does not enforce it.
module key_press_classifier_unit #(
	parameter int KEY_COUNT = kpc_pkg::KEY_COUNT_DEFAULT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	kpc_in_if.sink                            key_in,
	kpc_out_if.source                         event_out,
	input  logic                              cfg_we,
	input  logic [kpc_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [kpc_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int LANE_COUNT =
		(KEY_COUNT > kpc_pkg::FIELD_KEYS) ? kpc_pkg::FIELD_KEYS : KEY_COUNT;

	logic [kpc_pkg::TICK_W-1:0] long_ticks_q;
	logic [kpc_pkg::TICK_W-1:0] window_len_q;
	logic                       accept;
	kpc_pkg::kpc_event_t        lane_events [LANE_COUNT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_ticks_q <= kpc_pkg::LONG_PRESS_RESET;
			window_len_q <= kpc_pkg::DOUBLE_WINDOW_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				kpc_pkg::CFG_LONG_PRESS:    long_ticks_q <= cfg_data[kpc_pkg::TICK_W-1:0];
				kpc_pkg::CFG_DOUBLE_WINDOW: window_len_q <= cfg_data[kpc_pkg::TICK_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign key_in.ready = !event_out.valid || event_out.ready;
	assign accept       = key_in.valid && key_in.ready;

	for (genvar g = 0; g < LANE_COUNT; g++) begin : g_lane
		kpc_lane u_lane (
			.clk        (clk),
			.arst_n     (arst_n),
			.accept     (accept),
			.pressed    (!key_in.key_levels[g]),
			.long_ticks (long_ticks_q),
			.window_len (window_len_q),
			.events     (lane_events[g])
		);
	end

	kpc_merge #(
		.LANE_COUNT (LANE_COUNT)
	) u_merge (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.lane_events (lane_events),
		.event_out   (event_out)
	);

endmodule

// ----- dv/testbench.sv -----
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LANES = kpc_pkg::KEY_COUNT_DEFAULT < kpc_pkg::FIELD_KEYS ?
		kpc_pkg::KEY_COUNT_DEFAULT : kpc_pkg::FIELD_KEYS;
	localparam int HOLD_CYCLES = 40;

	typedef struct packed {
		logic [kpc_pkg::FIELD_KEYS-1:0] short_mask;
		logic [kpc_pkg::FIELD_KEYS-1:0] double_mask;
		logic [kpc_pkg::FIELD_KEYS-1:0] long_mask;
	} event_masks_t;

	logic                            clk;
	logic                            arst_n;
	logic                            cfg_we;
	logic [kpc_pkg::CFG_INDEX_W-1:0] cfg_index;
	logic [kpc_pkg::CFG_DATA_W-1:0]  cfg_data;

	kpc_in_if  key_if ();
	kpc_out_if event_if ();

	key_press_classifier_unit #(
		.KEY_COUNT(kpc_pkg::KEY_COUNT_DEFAULT)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.key_in   (key_if),
		.event_out(event_if),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// Per-key state of the expected behaviour.
	kpc_pkg::phase_t            key_phase [kpc_pkg::FIELD_KEYS];
	logic [kpc_pkg::TICK_W-1:0] hold_count [kpc_pkg::FIELD_KEYS];
	logic                       window_active [kpc_pkg::FIELD_KEYS];
	logic [kpc_pkg::TICK_W-1:0] window_count [kpc_pkg::FIELD_KEYS];
	logic [kpc_pkg::TICK_W-1:0] long_limit;
	logic [kpc_pkg::TICK_W-1:0] window_len;

	logic [kpc_pkg::FIELD_KEYS-1:0] tick_queue[$];
	event_masks_t                   expected_events[$];

	// Press and release runs of the stimulus generator, carried across phases.
	int run_left [kpc_pkg::FIELD_KEYS];
	bit run_press [kpc_pkg::FIELD_KEYS];

	int  send_idle_pct;
	int  stall_pct;
	bit  hold_req;
	bit  hold_off;
	int  errors;
	int  ticks_sent;
	int  results_checked;
	int  short_total;
	int  double_total;
	int  long_total;

	always #2 clk = ~clk;

	function automatic event_masks_t classify_tick(logic [kpc_pkg::FIELD_KEYS-1:0] levels);
		event_masks_t m;
		bit pressed;
		bit doubled;
		m = '0;
		for (int k = 0; k < LANES; k++) begin
			pressed = !levels[k];
			doubled = 1'b0;
			case (key_phase[k])
				kpc_pkg::PH_DEBOUNCE:
					key_phase[k] = pressed ? kpc_pkg::PH_HELD : kpc_pkg::PH_IDLE;
				kpc_pkg::PH_HELD: begin
					if (!pressed) begin
						if (hold_count[k] <= long_limit) begin
							if (!window_active[k]) begin
								window_active[k] = 1'b1;
								window_count[k] = '0;
							end else begin
								m.double_mask[k] = 1'b1;
								window_active[k] = 1'b0;
								doubled = 1'b1;
							end
						end
						key_phase[k] = kpc_pkg::PH_IDLE;
					end else begin
						if (hold_count[k] > long_limit)
							m.long_mask[k] = 1'b1;
						if (hold_count[k] != kpc_pkg::TICK_MAX)
							hold_count[k] = hold_count[k] + 1'b1;
					end
				end
				default: begin
					if (pressed) begin
						key_phase[k] = kpc_pkg::PH_DEBOUNCE;
						hold_count[k] = '0;
					end else begin
						key_phase[k] = kpc_pkg::PH_IDLE;
					end
				end
			endcase
			if (window_active[k] && !doubled) begin
				if (window_count[k] != kpc_pkg::TICK_MAX)
					window_count[k] = window_count[k] + 1'b1;
				if (window_count[k] >= window_len) begin
					m.short_mask[k] = 1'b1;
					window_active[k] = 1'b0;
				end
			end
		end
		return m;
	endfunction

	function automatic void check_mask(string what, logic [kpc_pkg::FIELD_KEYS-1:0] want,
		logic [kpc_pkg::FIELD_KEYS-1:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s mismatch, expected %h, got %h", $realtime, what, want, got);
		end
	endfunction

	// Driver: offers scan ticks from the pending queue and predicts each accepted one.
	always @(posedge clk) begin
		if (!arst_n) begin
			key_if.valid <= 1'b0;
		end else begin
			if (key_if.valid && key_if.ready) begin
				expected_events.push_back(classify_tick(key_if.key_levels));
				ticks_sent++;
			end
			if (!key_if.valid || key_if.ready) begin
				if (tick_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					key_if.valid <= 1'b1;
					key_if.key_levels <= tick_queue.pop_front();
				end else begin
					key_if.valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: takes event transactions and compares them with the oldest prediction.
	always @(posedge clk) begin
		event_masks_t want;
		if (!arst_n) begin
			event_if.ready <= 1'b0;
		end else begin
			if (event_if.valid && event_if.ready) begin
				if (expected_events.size() == 0) begin
					errors++;
					$display("%0t: event transaction with none expected, got %h %h %h",
						$realtime, event_if.short_events, event_if.double_events,
						event_if.long_events);
				end else begin
					want = expected_events.pop_front();
					check_mask("short_events", want.short_mask, event_if.short_events);
					check_mask("double_events", want.double_mask, event_if.double_events);
					check_mask("long_events", want.long_mask, event_if.long_events);
					results_checked++;
					short_total += $countones(want.short_mask);
					double_total += $countones(want.double_mask);
					long_total += $countones(want.long_mask);
				end
			end
			event_if.ready <= !hold_off && ($urandom_range(99) >= stall_pct);
		end
	end

	// Long receiver hold-off, counted here so that the sender keeps offering meanwhile.
	always begin
		@(posedge clk);
		if (hold_req) begin
			hold_off <= 1'b1;
			repeat (HOLD_CYCLES) @(posedge clk);
			hold_off <= 1'b0;
			hold_req <= 1'b0;
		end
	end

	task automatic write_reg(logic [kpc_pkg::CFG_INDEX_W-1:0] idx,
		logic [kpc_pkg::CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		if (idx == kpc_pkg::CFG_LONG_PRESS)
			long_limit = value;
		else if (idx == kpc_pkg::CFG_DOUBLE_WINDOW)
			window_len = value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_config(int thr, int win);
		write_reg(kpc_pkg::CFG_LONG_PRESS, thr[kpc_pkg::CFG_DATA_W-1:0]);
		write_reg(kpc_pkg::CFG_DOUBLE_WINDOW, win[kpc_pkg::CFG_DATA_W-1:0]);
	endtask

	task automatic set_idling(int send_pct, int recv_pct);
		@(posedge clk);
		send_idle_pct <= send_pct;
		stall_pct <= recv_pct;
	endtask

	task automatic wait_idle();
		@(negedge clk);
		while (tick_queue.size() > 0 || key_if.valid || expected_events.size() > 0)
			@(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic force_run(int k, bit press, int len);
		run_press[k] = press;
		run_left[k] = len;
	endtask

	// Each key follows its own run of presses and gaps sized around the threshold
	// and the window, so that bounces, clicks, double clicks and long holds all occur.
	task automatic queue_ticks(int count, int thr, int win, bit noisy);
		logic [kpc_pkg::FIELD_KEYS-1:0] levels;
		int pick;
		for (int t = 0; t < count; t++) begin
			for (int k = 0; k < kpc_pkg::FIELD_KEYS; k++) begin
				if (run_left[k] <= 0) begin
					run_press[k] = !run_press[k];
					pick = $urandom_range(9);
					if (run_press[k]) begin
						if (pick == 0)
							run_left[k] = 1;
						else if (pick < 5)
							run_left[k] = $urandom_range(thr + 2, 2);
						else if (pick < 8)
							run_left[k] = thr + 1 + $urandom_range(3);
						else
							run_left[k] = thr + 3 + $urandom_range(10);
					end else begin
						if (pick < 6)
							run_left[k] = $urandom_range(win + 1, 1);
						else
							run_left[k] = win + $urandom_range(6);
						if (run_left[k] == 0)
							run_left[k] = 1;
					end
				end
				levels[k] = !run_press[k];
				run_left[k]--;
			end
			if (noisy)
				levels = kpc_pkg::FIELD_KEYS'($urandom_range(15));
			tick_queue.push_back(levels);
		end
	endtask

	initial begin
		logic [kpc_pkg::FIELD_KEYS-1:0] directed[$];
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = kpc_pkg::CFG_LONG_PRESS;
		cfg_data = '0;
		key_if.valid = 1'b0;
		key_if.key_levels = '1;
		event_if.ready = 1'b0;
		send_idle_pct = 0;
		stall_pct = 0;
		hold_req = 1'b0;
		hold_off = 1'b0;
		long_limit = kpc_pkg::LONG_PRESS_RESET;
		window_len = kpc_pkg::DOUBLE_WINDOW_RESET;
		for (int k = 0; k < kpc_pkg::FIELD_KEYS; k++) begin
			key_phase[k] = kpc_pkg::PH_IDLE;
			hold_count[k] = '0;
			window_active[k] = 1'b0;
			window_count[k] = '0;
			run_left[k] = 0;
			run_press[k] = 1'b0;
		end
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Register values as left by reset.
		queue_ticks(60, kpc_pkg::LONG_PRESS_RESET, kpc_pkg::DOUBLE_WINDOW_RESET, 1'b0);
		wait_idle();

		// Directed ticks: long hold on all keys, double clicks, short clicks and a bounce.
		set_config(1, 4);
		directed = {4'hF, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'hF,
			4'hA, 4'hA, 4'hF, 4'hA, 4'hA, 4'hF, 4'hF,
			4'h5, 4'h5, 4'hF, 4'hF, 4'hF, 4'hF,
			4'h0, 4'hF};
		foreach (directed[i])
			tick_queue.push_back(directed[i]);
		wait_idle();

		set_config(3, 6);
		set_idling(57, 0);
		queue_ticks(60, 3, 6, 1'b0);
		wait_idle();

		// Zero threshold and zero window; the receiver holds off while ticks keep coming.
		set_config(0, 0);
		set_idling(0, 57);
		queue_ticks(70, 0, 0, 1'b0);
		@(posedge clk);
		hold_req <= 1'b1;
		@(posedge clk);
		while (hold_req)
			@(posedge clk);
		wait_idle();

		set_config(5, 10);
		set_idling(38, 38);
		queue_ticks(60, 5, 10, 1'b0);
		wait_idle();
		queue_ticks(60, 5, 10, 1'b0);
		wait_idle();

		// Largest useful threshold and longest window: the hold counter saturates.
		set_config(254, 255);
		set_idling(0, 0);
		force_run(0, 1'b1, 265);
		force_run(1, 1'b1, 3);
		queue_ticks(3, 254, 255, 1'b0);
		force_run(1, 1'b0, 262);
		queue_ticks(267, 254, 255, 1'b0);
		wait_idle();

		// A threshold that can never be passed, with a one-tick window.
		set_config(255, 1);
		force_run(0, 1'b1, 262);
		queue_ticks(265, 255, 1, 1'b0);
		wait_idle();

		set_config(2, 3);
		set_idling(38, 38);
		queue_ticks(40, 2, 3, 1'b1);
		queue_ticks(40, 2, 3, 1'b0);
		wait_idle();

		repeat (8) @(posedge clk);
		$display("Covered %0d scan ticks, %0d checked, over eight register settings",
			ticks_sent, results_checked);
		$display("Key events seen: %0d short, %0d double click, %0d long",
			short_total, double_total, long_total);
		if (errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	initial begin
		#400000;
		$display("Timed out with %0d transactions outstanding", expected_events.size());
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
